@@ hw/rtl/numeric_literal_classifier_macros.svh @@
// Assertion macros for the numeric literal classifier.
// Used by the top level; no other dependencies.
`ifndef NUMERIC_LITERAL_CLASSIFIER_MACROS_SVH
`define NUMERIC_LITERAL_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
// Check that ante implies cons in the same cycle.
`define NLC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Check that ante implies cons in the following cycle.
`define NLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define NLC_ASSERT_IMP(label, clk, rst, ante, cons)
`define NLC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/nlc_pkg.sv @@
// Package for the numeric literal classifier: state encodings, result struct
// and character class helpers. No dependencies.
`default_nettype none

package nlc_pkg;

  // Number automaton states
  typedef enum logic [4:0] {
    NS_START  = 5'd0,
    NS_MINUS  = 5'd1,
    NS_ZERO_P = 5'd2,
    NS_ZERO_N = 5'd3,
    NS_X_P    = 5'd4,
    NS_X_N    = 5'd5,
    NS_HEX_P  = 5'd6,
    NS_HEX_N  = 5'd7,
    NS_INT    = 5'd8,
    NS_DOT0   = 5'd9,
    NS_FRAC   = 5'd10,
    NS_EXP    = 5'd11,
    NS_EPLUS  = 5'd12,
    NS_EMINUS = 5'd13,
    NS_EINT   = 5'd14,
    NS_EDOT0  = 5'd15,
    NS_EFRAC  = 5'd16,
    NS_FAIL   = 5'd17
  } num_state_t;

  // Identifier automaton states
  typedef enum logic [1:0] {
    ID_START = 2'd0,
    ID_OK    = 2'd1,
    ID_FAIL  = 2'd2
  } id_state_t;

  // Classification of one token
  typedef struct packed {
    logic is_identifier;
    logic is_hex;
    logic is_integer;
    logic is_decimal;
    logic is_scientific;
    logic is_float;
  } nlc_class_t;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_EXP_U = 8'h45;
  localparam logic [7:0] CH_EXP_L = 8'h65;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic is_hexdig(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return (c == CH_EXP_U) || (c == CH_EXP_L);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/numeric_literal_classifier.sv @@
// Numeric literal classifier, top level.
// Depends on nlc_pkg, nlc_fsm and numeric_literal_classifier_macros.svh.
//
// Usage:
//   The input channel (in_valid, in_stall, char_code, last) carries a token
//   one byte per item; last marks the final byte. The output channel
//   (out_valid, out_stall, is_*) carries one classification per token,
//   issued for the item that has last set. Items without last produce no
//   output; they only advance the two automata.
//   A byte accepted from the input channel is held in the input register;
//   the result of a final byte is then loaded into the output register
//   once that register is free (not valid, or not stalled).
//   Throughput: one byte per cycle while in_stall is low, set by the single
//   automaton step that sits between the input register and the output register.
//   When the receiver stalls, the result stays in the output register; the
//   input register still drains bytes without last, and takes a new byte
//   whenever its current one moves on, so in_stall rises only when a final
//   byte waits for a full output register.
//   Reset (rst, synchronous, active high) empties both registers and puts
//   both automata at the start of a token.
`default_nettype none
`include "numeric_literal_classifier_macros.svh"

module numeric_literal_classifier
  import nlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_identifier,
  output logic       is_hex,
  output logic       is_integer,
  output logic       is_decimal,
  output logic       is_scientific,
  output logic       is_float
);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;

  // Automaton state
  num_state_t num_state;
  id_state_t  id_state;
  num_state_t num_next;
  id_state_t  id_next;
  nlc_class_t cls_next;

  // Output register
  nlc_class_t out_cls;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  nlc_fsm u_fsm (
    .num_state (num_state),
    .id_state  (id_state),
    .char_code (s1_char),
    .num_next  (num_next),
    .id_next   (id_next),
    .cls       (cls_next)
  );

  // Move the held byte on unless it is final and the output is blocked
  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && (!s1_last || out_free);
  assign in_stall = s1_valid && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire || s1_fire) begin
      s1_valid <= in_fire;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char <= char_code;
      s1_last <= last;
    end
  end

  // Step the automata; return to token start after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      num_state <= NS_START;
      id_state  <= ID_START;
    end else if (s1_fire) begin
      num_state <= s1_last ? NS_START : num_next;
      id_state  <= s1_last ? ID_START : id_next;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_fire && s1_last;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_cls <= cls_next;
    end
  end

  assign is_identifier = out_cls.is_identifier;
  assign is_hex        = out_cls.is_hex;
  assign is_integer    = out_cls.is_integer;
  assign is_decimal    = out_cls.is_decimal;
  assign is_scientific = out_cls.is_scientific;
  assign is_float      = out_cls.is_float;

  // Checks
  `NLC_ASSERT_NEXT(a_token_restart, clk, rst, s1_fire && s1_last, (num_state == NS_START) && (id_state == ID_START))
  `NLC_ASSERT_IMP(a_stall_only_when_full, clk, rst, in_stall, s1_valid && s1_last && out_valid)
  `NLC_ASSERT_IMP(a_hex_classes, clk, rst, out_valid && out_cls.is_hex, out_cls.is_integer && out_cls.is_float && !out_cls.is_decimal)
  `NLC_ASSERT_IMP(a_float_source, clk, rst, out_valid && out_cls.is_float, out_cls.is_decimal || out_cls.is_scientific || out_cls.is_hex)

endmodule

`default_nettype wire

@@ hw/rtl/nlc_fsm.sv @@
// Next-state and classification logic of both token automata.
// Depends on nlc_pkg.
`default_nettype none

module nlc_fsm
  import nlc_pkg::*;
(
  input  num_state_t  num_state,
  input  id_state_t   id_state,
  input  logic [7:0]  char_code,
  output num_state_t  num_next,
  output id_state_t   id_next,
  output nlc_class_t  cls
);

  logic dig;
  logic word_ch;

  assign dig     = is_digit(char_code);
  assign word_ch = is_letter(char_code) || (char_code == CH_UNDER);

  // Advance the number automaton by one byte
  always_comb begin
    num_next = NS_FAIL;
    unique case (num_state)
      NS_START: begin
        if (char_code == CH_MINUS)     num_next = NS_MINUS;
        else if (char_code == CH_ZERO) num_next = NS_ZERO_P;
        else if (dig)                  num_next = NS_INT;
        else if (char_code == CH_DOT)  num_next = NS_DOT0;
      end
      NS_MINUS: begin
        if (char_code == CH_ZERO)     num_next = NS_ZERO_N;
        else if (dig)                 num_next = NS_INT;
        else if (char_code == CH_DOT) num_next = NS_DOT0;
      end
      NS_ZERO_P, NS_ZERO_N: begin
        if (char_code == CH_X)
          num_next = (num_state == NS_ZERO_P) ? NS_X_P : NS_X_N;
        else if (dig)                 num_next = NS_INT;
        else if (char_code == CH_DOT) num_next = NS_FRAC;
        else if (is_exp(char_code))   num_next = NS_EXP;
      end
      NS_X_P, NS_HEX_P: begin
        if (is_hexdig(char_code)) num_next = NS_HEX_P;
      end
      NS_X_N, NS_HEX_N: begin
        if (is_hexdig(char_code)) num_next = NS_HEX_N;
      end
      NS_INT: begin
        if (dig)                      num_next = NS_INT;
        else if (char_code == CH_DOT) num_next = NS_FRAC;
        else if (is_exp(char_code))   num_next = NS_EXP;
      end
      NS_DOT0: begin
        if (dig) num_next = NS_FRAC;
      end
      NS_FRAC: begin
        if (dig)                    num_next = NS_FRAC;
        else if (is_exp(char_code)) num_next = NS_EXP;
      end
      NS_EXP: begin
        if (char_code == CH_PLUS)       num_next = NS_EPLUS;
        else if (char_code == CH_MINUS) num_next = NS_EMINUS;
        else if (dig)                   num_next = NS_EINT;
        else if (char_code == CH_DOT)   num_next = NS_EDOT0;
      end
      NS_EPLUS: begin
        if (char_code == CH_MINUS)    num_next = NS_EMINUS;
        else if (dig)                 num_next = NS_EINT;
        else if (char_code == CH_DOT) num_next = NS_EDOT0;
      end
      NS_EMINUS: begin
        if (dig)                      num_next = NS_EINT;
        else if (char_code == CH_DOT) num_next = NS_EDOT0;
      end
      NS_EINT: begin
        if (dig)                      num_next = NS_EINT;
        else if (char_code == CH_DOT) num_next = NS_EFRAC;
      end
      NS_EDOT0, NS_EFRAC: begin
        if (dig) num_next = NS_EFRAC;
      end
      default: num_next = NS_FAIL;
    endcase
  end

  // Advance the identifier automaton by one byte
  always_comb begin
    unique case (id_state)
      ID_START: id_next = word_ch ? ID_OK : ID_FAIL;
      ID_OK:    id_next = (word_ch || dig) ? ID_OK : ID_FAIL;
      default:  id_next = ID_FAIL;
    endcase
  end

  // Decode the state reached at the final byte into token classes
  always_comb begin
    cls = '0;
    cls.is_identifier = (id_next == ID_OK);
    unique case (num_next) inside
      NS_ZERO_P, NS_ZERO_N, NS_INT: begin
        cls.is_integer = 1'b1;
        cls.is_decimal = 1'b1;
        cls.is_float   = 1'b1;
      end
      NS_HEX_P: begin
        cls.is_hex     = 1'b1;
        cls.is_integer = 1'b1;
        cls.is_float   = 1'b1;
      end
      NS_HEX_N: cls.is_integer = 1'b1;
      NS_FRAC: begin
        cls.is_decimal = 1'b1;
        cls.is_float   = 1'b1;
      end
      NS_EINT, NS_EFRAC: begin
        cls.is_scientific = 1'b1;
        cls.is_float      = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ tb/literal_class_checker.sv @@
// Checker for the numeric literal classifier: watches the byte and result
// channels, predicts the class of each token and compares. Depends on nlc_pkg.
module literal_class_checker
  import nlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       is_identifier,
  input  logic       is_hex,
  input  logic       is_integer,
  input  logic       is_decimal,
  input  logic       is_scientific,
  input  logic       is_float,
  output int         failures,
  output int         pending
);

  // Bit order of nlc_class_t, lowest bit first
  string field_label [6] = '{"is_float", "is_scientific", "is_decimal",
                             "is_integer", "is_hex", "is_identifier"};

  num_state_t num_st = NS_START;
  id_state_t  id_st  = ID_START;
  nlc_class_t class_due [$];
  int         errs = 0;

  function automatic logic dec_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic ascii_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic hex_digit(input logic [7:0] c);
    return dec_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic exp_mark(input logic [7:0] c);
    return (c == CH_EXP_U) || (c == CH_EXP_L);
  endfunction

  // Number automaton: one byte step
  function automatic num_state_t num_step(input num_state_t s, input logic [7:0] c);
    logic dg;
    dg = dec_digit(c);
    case (s)
      NS_START: begin
        if (c == CH_MINUS) return NS_MINUS;
        if (c == CH_ZERO) return NS_ZERO_P;
        if (dg) return NS_INT;
        if (c == CH_DOT) return NS_DOT0;
        return NS_FAIL;
      end
      NS_MINUS: begin
        if (c == CH_ZERO) return NS_ZERO_N;
        if (dg) return NS_INT;
        if (c == CH_DOT) return NS_DOT0;
        return NS_FAIL;
      end
      NS_ZERO_P, NS_ZERO_N: begin
        if (c == CH_X) return (s == NS_ZERO_P) ? NS_X_P : NS_X_N;
        if (dg) return NS_INT;
        if (c == CH_DOT) return NS_FRAC;
        if (exp_mark(c)) return NS_EXP;
        return NS_FAIL;
      end
      NS_X_P, NS_HEX_P: return hex_digit(c) ? NS_HEX_P : NS_FAIL;
      NS_X_N, NS_HEX_N: return hex_digit(c) ? NS_HEX_N : NS_FAIL;
      NS_INT: begin
        if (dg) return NS_INT;
        if (c == CH_DOT) return NS_FRAC;
        if (exp_mark(c)) return NS_EXP;
        return NS_FAIL;
      end
      NS_DOT0: return dg ? NS_FRAC : NS_FAIL;
      NS_FRAC: begin
        if (dg) return NS_FRAC;
        if (exp_mark(c)) return NS_EXP;
        return NS_FAIL;
      end
      NS_EXP: begin
        if (c == CH_PLUS) return NS_EPLUS;
        if (c == CH_MINUS) return NS_EMINUS;
        if (dg) return NS_EINT;
        if (c == CH_DOT) return NS_EDOT0;
        return NS_FAIL;
      end
      NS_EPLUS: begin
        if (c == CH_MINUS) return NS_EMINUS;
        if (dg) return NS_EINT;
        if (c == CH_DOT) return NS_EDOT0;
        return NS_FAIL;
      end
      NS_EMINUS: begin
        if (dg) return NS_EINT;
        if (c == CH_DOT) return NS_EDOT0;
        return NS_FAIL;
      end
      NS_EINT: begin
        if (dg) return NS_EINT;
        if (c == CH_DOT) return NS_EFRAC;
        return NS_FAIL;
      end
      NS_EDOT0, NS_EFRAC: return dg ? NS_EFRAC : NS_FAIL;
      default: return NS_FAIL;
    endcase
  endfunction

  // Identifier automaton: one byte step
  function automatic id_state_t id_step(input id_state_t s, input logic [7:0] c);
    if (s == ID_START)
      return (ascii_letter(c) || c == CH_UNDER) ? ID_OK : ID_FAIL;
    if (s == ID_OK)
      return (ascii_letter(c) || dec_digit(c) || c == CH_UNDER) ? ID_OK : ID_FAIL;
    return ID_FAIL;
  endfunction

  // Map the final automaton states to the token class
  function automatic nlc_class_t classify_token(input num_state_t n, input id_state_t idn);
    nlc_class_t r;
    r = '0;
    r.is_identifier = (idn == ID_OK);
    case (n)
      NS_ZERO_P, NS_ZERO_N, NS_INT: begin
        r.is_integer = 1'b1;
        r.is_decimal = 1'b1;
        r.is_float   = 1'b1;
      end
      NS_HEX_P: begin
        r.is_hex     = 1'b1;
        r.is_integer = 1'b1;
        r.is_float   = 1'b1;
      end
      // a minus sign keeps hex out of the float class
      NS_HEX_N: r.is_integer = 1'b1;
      NS_FRAC: begin
        r.is_decimal = 1'b1;
        r.is_float   = 1'b1;
      end
      NS_EINT, NS_EFRAC: begin
        r.is_scientific = 1'b1;
        r.is_float      = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag(input string msg);
    errs++;
    if (errs <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    num_state_t nxt_num;
    id_state_t  nxt_id;
    logic [5:0] want, got;
    if (rst) begin
      class_due.delete();
      num_st = NS_START;
      id_st  = ID_START;
    end else begin
      // Advance both automata on each accepted item; predict at the last byte
      if (in_valid && !in_stall) begin
        nxt_num = num_step(num_st, char_code);
        nxt_id  = id_step(id_st, char_code);
        if (last) begin
          class_due.push_back(classify_token(nxt_num, nxt_id));
          num_st = NS_START;
          id_st  = ID_START;
        end else begin
          num_st = nxt_num;
          id_st  = nxt_id;
        end
      end
      // Compare each delivered result with the oldest prediction
      if (out_valid && !out_stall) begin
        got = {is_identifier, is_hex, is_integer, is_decimal, is_scientific, is_float};
        if (class_due.size() == 0) begin
          flag($sformatf("result %b with no token pending", got));
        end else begin
          want = class_due.pop_front();
          for (int b = 5; b >= 0; b--) begin
            if (got[b] !== want[b])
              flag($sformatf("%s expected %b got %b (class %b vs %b)",
                             field_label[b], want[b], got[b], want, got));
          end
        end
      end
    end
    pending  <= class_due.size();
    failures <= errs;
  end

endmodule

@@ tb/numeric_literal_classifier_test.sv @@
// Top of the numeric literal classifier testbench: clock, reset, token
// stimulus and verdict. Depends on nlc_pkg and literal_class_checker.
module numeric_literal_classifier_test;
  import nlc_pkg::*;

  localparam int ITEMS    = 950;
  localparam int WATCHDOG = 400;
  localparam logic [7:0] CH_X_UPPER = 8'h58;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] char_code;
  logic       last;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       is_identifier, is_hex, is_integer, is_decimal, is_scientific, is_float;
  int         failures;
  int         pending;

  logic       sink_mode = 1'b0;
  int         stall_left = 0;
  int         idle_cycles = 0;
  int         items_sent = 0;
  logic       gap_mode = 1'b0;
  logic [7:0] tok [$];

  string fixed_tokens [16] = '{"0", "-0x1fA", "0X1", "0x", ".", "-.5", "1.2.3", "0e+7",
                               "1.5e+-2.2", "9E.", "1e++5", "2e", "_a9Z", "9a", "-", "3."};

  always #2 clk = ~clk;

  numeric_literal_classifier dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .char_code(char_code), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_identifier(is_identifier), .is_hex(is_hex), .is_integer(is_integer),
    .is_decimal(is_decimal), .is_scientific(is_scientific), .is_float(is_float)
  );

  literal_class_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .char_code(char_code), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_identifier(is_identifier), .is_hex(is_hex), .is_integer(is_integer),
    .is_decimal(is_decimal), .is_scientific(is_scientific), .is_float(is_float),
    .failures(failures), .pending(pending)
  );

  // Stall the result channel in bursts while sink_mode is on
  always @(posedge clk) begin
    if (rst || !sink_mode) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 19);
      out_stall  <= 1'b1;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG) begin
      $display("numeric_literal_classifier_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_hex();
    case ($urandom_range(0, 2))
      0: return rand_digit();
      1: return 8'h61 + 8'($urandom_range(0, 5));
      default: return 8'h41 + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] rand_word_head();
    case ($urandom_range(0, 2))
      0: return 8'h41 + 8'($urandom_range(0, 25));
      1: return 8'h61 + 8'($urandom_range(0, 25));
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 8))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_DOT;
      3: return CH_EXP_U;
      4: return CH_EXP_L;
      5: return CH_X;
      6: return CH_X_UPPER;
      7: return CH_UNDER;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) tok.push_back(rand_digit());
  endtask

  // Build one random token: mostly well formed, some noise and corruption
  task automatic build_token();
    int kind;
    tok.delete();
    kind = $urandom_range(0, 7);
    if (kind <= 4 && $urandom_range(0, 3) == 0) tok.push_back(CH_MINUS);
    case (kind)
      0: begin
        tok.push_back(CH_ZERO);
        tok.push_back(($urandom_range(0, 7) == 0) ? CH_X_UPPER : CH_X);
        repeat ($urandom_range(0, 4)) tok.push_back(rand_hex());
      end
      1: add_digits(1, 5);
      2: begin
        add_digits(0, 3);
        tok.push_back(CH_DOT);
        add_digits(0, 3);
      end
      3, 4: begin
        add_digits(1, 3);
        if ($urandom_range(0, 1)) begin
          tok.push_back(CH_DOT);
          add_digits(0, 2);
        end
        tok.push_back($urandom_range(0, 1) ? CH_EXP_U : CH_EXP_L);
        if ($urandom_range(0, 2) == 0) tok.push_back(CH_PLUS);
        if ($urandom_range(0, 9) == 0) tok.push_back(CH_PLUS);
        if ($urandom_range(0, 2) == 0) tok.push_back(CH_MINUS);
        add_digits(0, 3);
        if ($urandom_range(0, 2) == 0) begin
          tok.push_back(CH_DOT);
          add_digits(0, 2);
        end
      end
      5, 6: begin
        tok.push_back(($urandom_range(0, 9) == 0) ? rand_digit() : rand_word_head());
        repeat ($urandom_range(0, 5))
          tok.push_back($urandom_range(0, 2) ? rand_word_head() : rand_digit());
      end
      default: repeat ($urandom_range(1, 4)) tok.push_back(8'($urandom_range(0, 255)));
    endcase
    // corrupt one byte now and then
    if ($urandom_range(0, 5) == 0) tok[$urandom_range(0, tok.size() - 1)] = odd_char();
  endtask

  // Offer one item, with an optional gap first, and hold it until taken
  task automatic send_item(input logic [7:0] c, input logic l);
    if (gap_mode && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last      <= l;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_token();
    foreach (tok[i]) send_item(tok[i], i == tok.size() - 1);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    char_code = '0;
    last      = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed tokens, then short tokens of odd bytes
    foreach (fixed_tokens[k]) begin
      tok.delete();
      for (int i = 0; i < fixed_tokens[k].len(); i++) tok.push_back(fixed_tokens[k][i]);
      send_token();
    end
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b1);
    send_item(8'h7f, 1'b1);
    send_item(8'h7a, 1'b0);
    send_item(8'h80, 1'b1);

    // Random tokens; the last stretch runs without gaps or stalls
    while (items_sent < ITEMS) begin
      if (items_sent > ITEMS - 150) begin
        gap_mode = 1'b0;
        sink_mode <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        gap_mode = 1'($urandom_range(0, 1));
        sink_mode <= 1'($urandom_range(0, 1));
      end
      build_token();
      send_token();
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("numeric_literal_classifier_test: clean");
    else
      $display("numeric_literal_classifier_test: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/nlc_pkg.sv
hw/rtl/nlc_fsm.sv
hw/rtl/numeric_literal_classifier.sv
tb/literal_class_checker.sv
tb/numeric_literal_classifier_test.sv
